FILE: src/crc16_ibm_ccitt_byte_stream_assert.svh
// assertion macros used by the crc16 core
`ifndef CRC16_IBM_CCITT_BYTE_STREAM_ASSERT_SVH
`define CRC16_IBM_CCITT_BYTE_STREAM_ASSERT_SVH

// implication checked in the same cycle, off during reset
`define CRC16_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("crc16 assertion failed");

// implication checked in the next cycle, off during reset
`define CRC16_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("crc16 assertion failed");

// implication checked in the next cycle, also across reset
`define CRC16_ASSERT_RESET(name, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("crc16 assertion failed");

`endif

FILE: src/crc16_pkg.sv
package crc16_pkg;

  localparam int unsigned CrcW = 16;
  localparam int unsigned ByteW = 8;
  localparam int unsigned CfgIdxW = 3;

  typedef logic [CrcW-1:0] crc_t;
  typedef logic [ByteW-1:0] data_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  // register indexes
  localparam cfg_idx_t REG_KIND = 3'd0;
  localparam cfg_idx_t REG_IBM_POLY = 3'd1;
  localparam cfg_idx_t REG_IBM_SEED = 3'd2;
  localparam cfg_idx_t REG_CCITT_POLY = 3'd3;
  localparam cfg_idx_t REG_CCITT_SEED = 3'd4;

  // crc kinds
  localparam logic KIND_IBM = 1'b0;
  localparam logic KIND_CCITT = 1'b1;

  // reset values
  localparam logic RST_KIND = KIND_CCITT;
  localparam crc_t RST_IBM_POLY = 16'h8005;
  localparam crc_t RST_IBM_SEED = 16'hFFFF;
  localparam crc_t RST_CCITT_POLY = 16'h1021;
  localparam crc_t RST_CCITT_SEED = 16'h1D0F;

  // settings of the selected kind
  typedef struct packed {
    logic ccitt;
    crc_t poly;
    crc_t seed;
  } sel_t;

  // finished crc handed to the output queue
  typedef struct packed {
    logic push;
    crc_t crc;
  } res_t;

endpackage

FILE: src/crc16_regs.sv
module crc16_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  crc16_pkg::cfg_idx_t cfg_index,
  input  crc16_pkg::crc_t     cfg_data,
  output crc16_pkg::sel_t     sel
);

  logic            kind;
  crc16_pkg::crc_t ibm_poly;
  crc16_pkg::crc_t ibm_seed;
  crc16_pkg::crc_t ccitt_poly;
  crc16_pkg::crc_t ccitt_seed;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kind       <= crc16_pkg::RST_KIND;
      ibm_poly   <= crc16_pkg::RST_IBM_POLY;
      ibm_seed   <= crc16_pkg::RST_IBM_SEED;
      ccitt_poly <= crc16_pkg::RST_CCITT_POLY;
      ccitt_seed <= crc16_pkg::RST_CCITT_SEED;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        crc16_pkg::REG_KIND:       kind       <= cfg_data[0];
        crc16_pkg::REG_IBM_POLY:   ibm_poly   <= cfg_data;
        crc16_pkg::REG_IBM_SEED:   ibm_seed   <= cfg_data;
        crc16_pkg::REG_CCITT_POLY: ccitt_poly <= cfg_data;
        crc16_pkg::REG_CCITT_SEED: ccitt_seed <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    sel.ccitt = (kind == crc16_pkg::KIND_CCITT);
    sel.poly  = sel.ccitt ? ccitt_poly : ibm_poly;
    sel.seed  = sel.ccitt ? ccitt_seed : ibm_seed;
  end

endmodule

FILE: src/crc16_core.sv
module crc16_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             byte_valid,
  output logic             byte_stall,
  input  crc16_pkg::data_t data_byte,
  input  logic             first_byte,
  input  logic             last_byte,
  input  crc16_pkg::sel_t  sel,
  input  logic             q_full,
  output crc16_pkg::res_t  res
);

  `include "crc16_ibm_ccitt_byte_stream_assert.svh"

  logic             s1_valid;
  logic             s1_valid_next;
  crc16_pkg::data_t s1_byte;
  logic             s1_first;
  logic             s1_last;
  crc16_pkg::crc_t  running_crc;
  crc16_pkg::crc_t  folded;
  logic             advance;
  logic             accept;

  assign advance    = s1_valid && (!s1_last || !q_full);
  assign byte_stall = s1_valid && !advance;
  assign accept     = byte_valid && !byte_stall;

  always_comb begin
    s1_valid_next = s1_valid;
    if (accept) begin
      s1_valid_next = 1'b1;
    end else if (advance) begin
      s1_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte  <= data_byte;
      s1_first <= first_byte;
      s1_last  <= last_byte;
    end
  end

  // eight msb-first shift and xor steps
  always_comb begin
    crc16_pkg::crc_t  c;
    crc16_pkg::data_t d;
    c = s1_first ? sel.seed : running_crc;
    d = s1_byte;
    for (int k = 0; k < crc16_pkg::ByteW; k++) begin
      if (c[crc16_pkg::CrcW-1] ^ d[crc16_pkg::ByteW-1]) begin
        c = {c[crc16_pkg::CrcW-2:0], 1'b0} ^ sel.poly;
      end else begin
        c = {c[crc16_pkg::CrcW-2:0], 1'b0};
      end
      d = {d[crc16_pkg::ByteW-2:0], 1'b0};
    end
    folded = c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= '0;
    end else if (advance) begin
      running_crc <= folded;
    end
  end

  assign res.push = advance && s1_last;
  assign res.crc  = sel.ccitt ? ~folded : folded;

  `CRC16_ASSERT_RESET(a_reset_empties_stage, rst, !s1_valid)
  `CRC16_ASSERT_NEXT(a_held_item_stable, byte_stall,
                     s1_valid && $stable(s1_byte) && $stable(s1_last))
  `CRC16_ASSERT_NEXT(a_crc_holds_when_idle, !advance, $stable(running_crc))
  `CRC16_ASSERT_SAME(a_no_push_when_full, q_full, !res.push)

endmodule

FILE: src/crc16_outq.sv
module crc16_outq (
  input  logic            clk,
  input  logic            rst,
  input  crc16_pkg::res_t res,
  output logic            q_full,
  output logic            crc_valid,
  input  logic            crc_stall,
  output crc16_pkg::crc_t crc_result
);

  crc16_pkg::crc_t mem [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic [1:0]      count_next;
  logic            pop;

  assign crc_valid  = (count != 2'd0);
  assign q_full     = (count == 2'd2);
  assign pop        = crc_valid && !crc_stall;
  assign crc_result = mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (res.push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !res.push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      count <= count_next;
      if (res.push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res.push) begin
      mem[wr_ptr] <= res.crc;
    end
  end

endmodule

FILE: src/crc16_ibm_ccitt_byte_stream.sv
// a last byte goes through the s1 register, then the output queue, to crc_valid
// throughput: one byte per cycle from the single-pass fold, unless a last byte
// meets a full two-entry output queue, which lets bytes flow while a result waits
// synchronous reset clears the running crc to zero and restores register defaults
module crc16_ibm_ccitt_byte_stream (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_stall,
  input  crc16_pkg::data_t    data_byte,
  input  logic                first_byte,
  input  logic                last_byte,
  output logic                crc_valid,
  input  logic                crc_stall,
  output crc16_pkg::crc_t     crc_result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  crc16_pkg::cfg_idx_t cfg_index,
  input  crc16_pkg::crc_t     cfg_data
);

  crc16_pkg::sel_t sel;
  crc16_pkg::res_t res;
  logic            q_full;

  crc16_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sel       (sel)
  );

  crc16_core u_core (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .data_byte  (data_byte),
    .first_byte (first_byte),
    .last_byte  (last_byte),
    .sel        (sel),
    .q_full     (q_full),
    .res        (res)
  );

  crc16_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .res        (res),
    .q_full     (q_full),
    .crc_valid  (crc_valid),
    .crc_stall  (crc_stall),
    .crc_result (crc_result)
  );

endmodule
